// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sampler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off during reset.
`define STS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, off during reset.
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sts_pkg.sv -----
// Package of the sparse ternary sampler: sizes, codes, structs.
// No dependencies; the interfaces and every RTL module import it.
package sts_pkg;

  // Largest vector size; a power of two of at least 128.
  localparam int MAX_SIZE   = 4096;
  localparam int POS_W      = $clog2(MAX_SIZE);
  // Bitmap is kept as rows; at most 256 rows so each row gets a valid flop.
  localparam int COL_W      = (POS_W > 14) ? (POS_W - 8) : 6;
  localparam int ROW_W      = 2 ** COL_W;
  localparam int ROW_AW     = POS_W - COL_W;
  localparam int ROWS       = 2 ** ROW_AW;

  localparam int SIZE_W     = 13;
  localparam int CNT_W      = 13;
  localparam int WORD_W     = 64;
  localparam int COEF_W     = 64;
  localparam int POSITION_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SIZE_W-1:0] SIZE_RST    = 13'd4096;
  localparam logic [CNT_W-1:0]  WEIGHT_RST  = 13'd64;
  localparam logic [COEF_W-1:0] MODULUS_RST = 64'd65537;

  // Command queue between front and back, result queue at the output.
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OAW       = $clog2(OUT_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE    = 2'd0,
    CFG_WEIGHT  = 2'd1,
    CFG_MODULUS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_WORD  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [SIZE_W-1:0] size_in_use;
    logic [CNT_W-1:0]  weight;
    logic [COEF_W-1:0] modulus;
  } cfg_t;

  typedef struct packed {
    req_type_e        req;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [POSITION_W-1:0] position;
    logic [COEF_W-1:0]     coefficient;
    logic                  accepted;
    logic                  last;
  } rsp_t;

  // Queue status seen by the front end and the top-level checks.
  typedef struct packed {
    logic push;
    logic full;
  } q_stat_t;

endpackage

// ----- rtl/sts_if.sv -----
// Handshake channels of the sampler: request, result and register write.
// Depends on sts_pkg.
interface sts_in_if;
  import sts_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [WORD_W-1:0] random_word;
  modport source (output valid, req_type, random_word, input ready);
  modport sink   (input valid, req_type, random_word, output ready);
endinterface

interface sts_out_if;
  import sts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [POSITION_W-1:0] position;
  logic [COEF_W-1:0]     coefficient;
  logic                  accepted;
  logic                  last;
  modport source (output valid, position, coefficient, accepted, last, input ready);
  modport sink   (input valid, position, coefficient, accepted, last, output ready);
endinterface

interface sts_cfg_if;
  import sts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sts_front.sv -----
// Front end: takes request words, scales random words to a position.
// Depends on sts_pkg and sts_if; feeds sts_queue.
module sts_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sts_in_if.sink        req_i,
  input  sts_pkg::cfg_t cfg_i,
  input  logic          full_i,
  output logic          push_o,
  output sts_pkg::cmd_t cmd_o
);
  import sts_pkg::*;

  localparam int PROD_W = 32 + SIZE_W;
  localparam int P_W    = PROD_W - 31;

  logic              s1_vld_q, s1_vld_d;
  req_type_e         s1_req_q;
  logic [PROD_W-1:0] prod_lo_q, prod_hi_q;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] size_eff;
  logic              take;
  logic [PROD_W:0]   sum;
  logic [P_W-1:0]    p;

  assign req_i.ready = !s1_vld_q || !full_i;
  assign take        = req_i.valid && req_i.ready;
  assign push_o      = s1_vld_q;

  // saturate the size register to the bitmap size
  always_comb begin
    size_eff = cfg_i.size_in_use;
    if (32'(cfg_i.size_in_use) > MAX_SIZE) begin
      size_eff = SIZE_W'(MAX_SIZE);
    end
  end

  // round(word * size / 2^64) from the two registered partial products
  always_comb begin
    sum = {1'b0, prod_hi_q} + (PROD_W+1)'(prod_lo_q >> 32) + (PROD_W+1)'(33'h0_8000_0000);
    p   = sum[PROD_W:32];
    cmd_o.req = s1_req_q;
    cmd_o.pos = '0;
    if (p < P_W'(size_q)) begin
      cmd_o.pos = POS_W'(p);
    end
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (take) begin
      s1_vld_d = 1'b1;
    end else if (s1_vld_q && !full_i) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_req_q  <= req_type_e'(req_i.req_type);
      prod_lo_q <= PROD_W'(req_i.random_word[31:0]) * PROD_W'(size_eff);
      prod_hi_q <= PROD_W'(req_i.random_word[63:32]) * PROD_W'(size_eff);
      size_q    <= size_eff;
    end
  end

endmodule

// ----- rtl/sts_queue.sv -----
// Short command queue between front end and back end.
// Depends on sts_pkg.
module sts_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sts_pkg::cmd_t   cmd_i,
  output sts_pkg::q_stat_t stat_o,
  output logic            vld_o,
  output sts_pkg::cmd_t   cmd_o,
  input  logic            pop_i
);
  import sts_pkg::*;

  cmd_t           ent_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign stat_o.full = (cnt_q == (QAW+1)'(QDEPTH));
  assign stat_o.push = push_i;
  assign vld_o       = (cnt_q != '0);
  assign cmd_o       = ent_q[rd_ptr_q];
  assign do_push     = push_i && !stat_o.full;
  assign do_pop      = pop_i && vld_o;

  always_comb begin
    cnt_d = cnt_q + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/sts_back.sv -----
// Back end: bitmap read-modify-write, placed count, sign, result queue.
// Depends on sts_pkg and sts_if; fed by sts_queue.
module sts_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sts_pkg::cfg_t cfg_i,
  input  logic          q_vld_i,
  input  sts_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  sts_out_if.source     rsp_o
);
  import sts_pkg::*;

  // bitmap rows, plus one valid flop per row (clear = empty row)
  logic [ROW_W-1:0]  mem_q [ROWS];
  logic [ROWS-1:0]   row_vld_q;
  logic [ROW_W-1:0]  rd_data_q;

  logic              u_vld_q;
  cmd_t              u_cmd_q;

  // last write, for a read that raced it
  logic              fwd_vld_q;
  logic [ROW_AW-1:0] fwd_row_q;
  logic [ROW_W-1:0]  fwd_data_q;

  logic [CNT_W-1:0]  placed_q, placed_d;
  logic              neg_q, neg_d;

  rsp_t              oq_q [OUT_DEPTH];
  logic [OAW-1:0]    oq_wr_q, oq_rd_q;
  logic [OAW:0]      oq_cnt_q;
  logic [OAW+1:0]    inflight;

  logic [ROW_AW-1:0] row, rd_row;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  eff_row, wr_data;
  logic              wr_en, clr;
  rsp_t              rsp;
  logic              oq_pop;

  // pop only when the result queue has room for everything in flight
  assign inflight = (OAW+2)'(oq_cnt_q) + (OAW+2)'(u_vld_q);
  assign q_pop_o  = q_vld_i && (inflight < (OAW+2)'(OUT_DEPTH));
  assign rd_row   = q_cmd_i.pos[POS_W-1:COL_W];

  assign row = u_cmd_q.pos[POS_W-1:COL_W];
  assign col = u_cmd_q.pos[COL_W-1:0];

  always_comb begin
    if (fwd_vld_q && (fwd_row_q == row)) begin
      eff_row = fwd_data_q;
    end else if (row_vld_q[row]) begin
      eff_row = rd_data_q;
    end else begin
      eff_row = '0;
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    clr      = 1'b0;
    wr_data  = eff_row | (ROW_W'(1) << col);
    placed_d = placed_q;
    neg_d    = neg_q;
    rsp      = '0;
    if (u_vld_q) begin
      case (u_cmd_q.req)
        REQ_START: begin
          clr      = 1'b1;
          placed_d = '0;
          neg_d    = 1'b0;
          rsp.last = (cfg_i.weight == '0);
        end
        REQ_WORD: begin
          if (placed_q >= cfg_i.weight) begin
            rsp.last = 1'b1;
          end else begin
            rsp.position = POSITION_W'(u_cmd_q.pos);
            if (!eff_row[col]) begin
              wr_en           = 1'b1;
              placed_d        = placed_q + CNT_W'(1);
              neg_d           = !neg_q;
              rsp.accepted    = 1'b1;
              rsp.coefficient = neg_q ? (cfg_i.modulus - COEF_W'(1)) : COEF_W'(1);
              rsp.last        = (placed_d >= cfg_i.weight);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign oq_pop            = rsp_o.valid && rsp_o.ready;
  assign rsp_o.valid       = (oq_cnt_q != '0);
  assign rsp_o.position    = oq_q[oq_rd_q].position;
  assign rsp_o.coefficient = oq_q[oq_rd_q].coefficient;
  assign rsp_o.accepted    = oq_q[oq_rd_q].accepted;
  assign rsp_o.last        = oq_q[oq_rd_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_vld_q   <= 1'b0;
      placed_q  <= '0;
      neg_q     <= 1'b0;
      row_vld_q <= '0;
      fwd_vld_q <= 1'b0;
      oq_wr_q   <= '0;
      oq_rd_q   <= '0;
      oq_cnt_q  <= '0;
    end else begin
      u_vld_q   <= q_pop_o;
      placed_q  <= placed_d;
      neg_q     <= neg_d;
      fwd_vld_q <= wr_en;
      if (clr) begin
        row_vld_q <= '0;
      end else if (wr_en) begin
        row_vld_q[row] <= 1'b1;
      end
      if (u_vld_q) begin
        oq_wr_q <= oq_wr_q + OAW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OAW'(1);
      end
      oq_cnt_q <= oq_cnt_q + (OAW+1)'(u_vld_q) - (OAW+1)'(oq_pop);
    end
  end

  // bitmap: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[row] <= wr_data;
    end
    rd_data_q <= mem_q[rd_row];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      u_cmd_q <= q_cmd_i;
    end
    fwd_row_q  <= row;
    fwd_data_q <= wr_data;
    if (u_vld_q) begin
      oq_q[oq_wr_q] <= rsp;
    end
  end

endmodule

// ----- rtl/sparse_ternary_sampler.sv -----
// Sparse ternary sampler top: config registers, front end, queue, back end.
// Path to rsp_o: front product registers, command queue, bitmap update stage, result queue.
// Throughput: one word per cycle while rsp_o is not stalled, set by the bitmap's single
//   read-modify-write per word with forwarding of the previous row write.
// Reset: registers take their reset values, the bitmap reads as empty through
//   one valid flop per row; no clearing pass. A start word empties it by clearing every valid flop.
`include "assert_macros.svh"

module sparse_ternary_sampler (
  input  logic      clk_i,
  input  logic      rst_ni,
  sts_in_if.sink    req_i,
  sts_out_if.source rsp_o,
  sts_cfg_if.sink   cfg_i
);
  import sts_pkg::*;

  cfg_t    cfg_q;
  logic    q_push;
  cmd_t    q_in_cmd, q_out_cmd;
  q_stat_t q_stat;
  logic    q_vld, q_pop;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_in_use <= SIZE_RST;
      cfg_q.weight      <= WEIGHT_RST;
      cfg_q.modulus     <= MODULUS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_SIZE:    cfg_q.size_in_use <= cfg_i.data[SIZE_W-1:0];
        CFG_WEIGHT:  cfg_q.weight      <= cfg_i.data[CNT_W-1:0];
        CFG_MODULUS: cfg_q.modulus     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // front: scale the random word to a position (two registered partial products)
  sts_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .full_i (q_stat.full),
    .push_o (q_push),
    .cmd_o  (q_in_cmd)
  );

  sts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_in_cmd),
    .stat_o (q_stat),
    .vld_o  (q_vld),
    .cmd_o  (q_out_cmd),
    .pop_i  (q_pop)
  );

  // back: occupancy check, count and sign update, result queue
  sts_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .q_vld_i (q_vld),
    .q_cmd_i (q_out_cmd),
    .q_pop_o (q_pop),
    .rsp_o   (rsp_o)
  );

  // front end keeps offering its held word while the queue is full
  `STS_ASSERT_IMPL(a_front_hold, clk_i, rst_ni, $past(q_stat.full && q_stat.push), q_stat.push, "held word dropped")
  // only a placed entry carries a nonzero coefficient
  `STS_ASSERT_IMPL(a_coef_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.accepted, rsp_o.coefficient == '0, "coefficient on unplaced word")
  // unplaced words flagged last (start with zero weight, or post-completion) report position zero
  `STS_ASSERT_IMPL(a_last_pos_zero, clk_i, rst_ni, rsp_o.valid && rsp_o.last && !rsp_o.accepted, rsp_o.position == '0, "position on start or finished word")

endmodule
